@@ sv/usan_pkg.sv @@
// shared types and byte constants for the utf-8 sanitizer
`default_nettype none
package usan_pkg;

  localparam logic [7:0] REPL_B0     = 8'hEF;
  localparam logic [7:0] REPL_B1     = 8'hBF;
  localparam logic [7:0] REPL_B2     = 8'hBD;
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;
  localparam logic [7:0] E0_CONT_LO  = 8'hA0;
  localparam logic [7:0] ED_CONT_HI  = 8'h9F;
  localparam logic [7:0] F0_CONT_LO  = 8'h90;
  localparam logic [7:0] F4_CONT_HI  = 8'h8F;

  localparam logic [1:0] PH_B0 = 2'd0;
  localparam logic [1:0] PH_B1 = 2'd1;
  localparam logic [1:0] PH_B2 = 2'd2;

  // one queued job: nrep replacements, then nraw raw bytes
  typedef struct packed {
    logic [2:0]       nrep;
    logic [2:0]       nraw;
    logic [3:0][7:0]  raw;
    logic             eol;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

@@ sv/usan_front.sv @@
// front end: decodes each byte against the held sequence and builds output jobs
`default_nettype none
module usan_front
  import usan_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_line,
  output job_t            job,
  output logic            job_push
);

  logic       pass_r;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] cont_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] len_r, len_nxt;
  logic       cont_we;
  logic       cont_sel;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    l = 3'd0;
    if (b <= ASCII_MAX) l = 3'd1;
    else if (b >= LEAD2_LO && b <= LEAD2_HI) l = 3'd2;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) l = 3'd3;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) l = 3'd4;
    return l;
  endfunction

  function automatic logic cont_ok(input logic [7:0] lead, input logic first,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = CONT_LO;
    hi = CONT_HI;
    if (first) begin
      if (lead == LEAD3_LO) lo = E0_CONT_LO;
      else if (lead == LEAD_ED) hi = ED_CONT_HI;
      else if (lead == LEAD4_LO) lo = F0_CONT_LO;
      else if (lead == LEAD4_HI) hi = F4_CONT_HI;
    end
    return (b >= lo) && (b <= hi);
  endfunction

  always_comb begin
    logic [2:0] ll;
    logic       do_lead;
    ll       = lead_len(in_byte);
    do_lead  = 1'b0;
    job      = '0;
    job.eol  = in_end_of_line;
    job.raw[0] = in_byte;
    lead_nxt = lead_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    cont_we  = 1'b0;
    cont_sel = 1'b0;
    if (pass_r) begin
      job.nraw = 3'd1;
      cnt_nxt  = 2'd0;
      len_nxt  = 3'd0;
    end else begin
      if (cnt_r != 2'd0 && {1'b0, cnt_r} < len_r) begin
        if (cont_ok(lead_r, cnt_r == 2'd1, in_byte)) begin
          if ({1'b0, cnt_r} + 3'd1 == len_r) begin
            job.nraw   = {1'b0, cnt_r} + 3'd1;
            job.raw[0] = lead_r;
            job.raw[1] = (cnt_r == 2'd1) ? in_byte : cont_r[0];
            job.raw[2] = (cnt_r == 2'd2) ? in_byte : cont_r[1];
            job.raw[3] = in_byte;
            cnt_nxt    = 2'd0;
            len_nxt    = 3'd0;
          end else begin
            cont_we  = 1'b1;
            cont_sel = (cnt_r == 2'd2);
            cnt_nxt  = cnt_r + 2'd1;
          end
        end else begin
          job.nrep = {1'b0, cnt_r};
          cnt_nxt  = 2'd0;
          len_nxt  = 3'd0;
          do_lead  = 1'b1;
        end
      end else begin
        cnt_nxt = 2'd0;
        len_nxt = 3'd0;
        do_lead = 1'b1;
      end
      if (do_lead) begin
        if (ll == 3'd1) begin
          job.nraw = 3'd1;
        end else if (ll == 3'd0) begin
          job.nrep = job.nrep + 3'd1;
        end else begin
          lead_nxt = in_byte;
          cnt_nxt  = 2'd1;
          len_nxt  = ll;
        end
      end
      if (in_end_of_line) begin
        job.nrep = job.nrep + {1'b0, cnt_nxt};
        cnt_nxt  = 2'd0;
        len_nxt  = 3'd0;
      end
    end
  end

  assign job_push = accept && (job.nrep != 3'd0 || job.nraw != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      lead_r <= 8'h00;
      cnt_r  <= 2'd0;
      len_r  <= 3'd0;
    end else begin
      if (cfg_wr_en) pass_r <= cfg_wr_data;
      if (accept) begin
        lead_r <= lead_nxt;
        cnt_r  <= cnt_nxt;
        len_r  <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cont_we) cont_r[cont_sel] <= in_byte;
  end

endmodule
`default_nettype wire

@@ sv/usan_queue.sv @@
// two-entry job queue between front and back
`default_nettype none
module usan_queue
  import usan_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head,
  output q_status_t  status
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_pop;

  assign status.not_empty = (count_r != 2'd0);
  assign status.full      = (count_r == 2'd2);
  assign head             = mem_r[rd_ptr_r];
  assign do_pop           = pop && status.not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !do_pop) count_r <= count_r + 2'd1;
      else if (!push && do_pop) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

@@ sv/usan_back.sv @@
// back end: expands the head job into output bytes, one per unstalled cycle
`default_nettype none
module usan_back
  import usan_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire q_status_t  status,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_line_done,
  output logic            out_substituted
);

  logic [2:0] rep_cnt_r;
  logic [1:0] phase_r;
  logic [2:0] raw_cnt_r;
  logic       in_rep;
  logic       last;
  logic       take;

  assign in_rep = (rep_cnt_r < head.nrep);
  assign last   = in_rep ? (head.nraw == 3'd0 && rep_cnt_r + 3'd1 == head.nrep &&
                            phase_r == PH_B2)
                         : (raw_cnt_r + 3'd1 == head.nraw);

  always_comb begin
    out_byte = head.raw[raw_cnt_r[1:0]];
    if (in_rep) begin
      unique case (phase_r)
        PH_B0:   out_byte = REPL_B0;
        PH_B1:   out_byte = REPL_B1;
        default: out_byte = REPL_B2;
      endcase
    end
  end

  assign out_valid       = status.not_empty;
  assign out_run_last    = last;
  assign out_line_done   = last && head.eol;
  assign out_substituted = in_rep;
  assign take            = out_valid && !out_stall;
  assign pop             = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_cnt_r <= 3'd0;
      phase_r   <= PH_B0;
      raw_cnt_r <= 3'd0;
    end else if (take) begin
      if (last) begin
        rep_cnt_r <= 3'd0;
        phase_r   <= PH_B0;
        raw_cnt_r <= 3'd0;
      end else if (in_rep) begin
        if (phase_r == PH_B2) begin
          phase_r   <= PH_B0;
          rep_cnt_r <= rep_cnt_r + 3'd1;
        end else begin
          phase_r <= phase_r + 2'd1;
        end
      end else begin
        raw_cnt_r <= raw_cnt_r + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/utf8_sanitizer.sv @@
// top level of the streaming utf-8 sanitizer
`default_nettype none
// Takes one byte per transaction and emits well-formed UTF-8, one byte per
// clock unless out_stall is high. The front end accepts a byte every cycle
// while its two-entry job queue has room; the back end drains one output
// byte per unstalled cycle, and an input byte yields 0 to 12 of them (a
// bad sequence gives EF BF BD per held byte). Valid text thus runs at one
// byte per such cycle; replacement bursts back-pressure the input through
// the queue. With pass_through set bytes are copied unchanged and any held
// sequence is dropped. cfg_wr_en/cfg_wr_data write pass_through, idle only.
module utf8_sanitizer
  import usan_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_line,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_line_done,
  output logic            out_substituted
);

  job_t      job;
  job_t      head;
  logic      job_push;
  logic      pop;
  logic      accept;
  q_status_t status;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  usan_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_line (in_end_of_line),
    .job            (job),
    .job_push       (job_push)
  );

  usan_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  usan_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .status          (status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_line_done   (out_line_done),
    .out_substituted (out_substituted)
  );

endmodule
`default_nettype wire
